// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file jtks_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is asserted (active low).
`define JTKS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is also checked through reset.
`define JTKS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/jtks_pkg.sv =====
// ----------------------------------------------------------------------------
// jtks_pkg
// Types and character constants for the JSON top-level type key scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jtks_pkg;

    // scan phase, one-hot
    typedef enum logic [3:0] {
        PH_LEAD   = 4'b0001,
        PH_SCAN   = 4'b0010,
        PH_DONE   = 4'b0100,
        PH_NONOBJ = 4'b1000
    } t_phase;

    // verdict codes
    localparam logic [1:0] VERDICT_INVALID = 2'd0;
    localparam logic [1:0] VERDICT_NONOBJ  = 2'd1;
    localparam logic [1:0] VERDICT_NOTYPE  = 2'd2;
    localparam logic [1:0] VERDICT_TYPE    = 2'd3;

    // characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // length of the key literal "type"
    localparam logic [2:0] KEY_LEN = 3'd4;

    // one byte handed from the input register to the scanner
    typedef struct packed {
        logic       fire;
        logic [7:0] text_byte;
    } t_step;

    // characters of the key literal
    function automatic logic [7:0] key_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h74; // t
            2'd1:    c = 8'h79; // y
            2'd2:    c = 8'h70; // p
            default: c = 8'h65; // e
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/jtks_if.sv =====
// ----------------------------------------------------------------------------
// jtks_byte_if / jtks_verdict_if
// Valid/ready channels for text bytes in and verdicts out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface jtks_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface jtks_verdict_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;

    modport source (output valid, output verdict, input ready);
    modport sink   (input valid, input verdict, output ready);
endinterface

`default_nettype wire

// ===== hdl/json_top_level_type_key_scanner.sv =====
// ----------------------------------------------------------------------------
// json_top_level_type_key_scanner
// Scans JSON text byte by byte; on the zero terminator reports whether the
// text is an object and whether it has a top-level "type" key.
// ----------------------------------------------------------------------------
//  channel     dir  payload            transaction
//  i_text      in   text_byte [7:0]    one character, 0 ends the text
//  o_verdict   out  verdict   [1:0]    one per terminator
//
//  One byte per cycle sustained: input register, one level of scanner logic,
//  verdict register. The verdict of a terminator is loaded into the verdict
//  register as the terminator leaves the input register. i_text only
//  stalls when a terminator sits in the input register and the previous
//  verdict has not been taken. Synchronous reset clears the scanner to the
//  leading-blank phase and empties both registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module json_top_level_type_key_scanner import jtks_pkg::*; #(
    parameter int MAX_DEPTH = 255
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    jtks_byte_if.sink       i_text,
    jtks_verdict_if.source  o_verdict
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    logic [1:0] r_verdict;

    logic       consume;
    logic       term;
    t_step      step;
    logic [1:0] core_verdict;

    assign term    = (r_in_byte == CH_NUL);
    // non-terminators never wait on the output side
    assign consume = r_in_valid && (!term || !r_out_valid || o_verdict.ready);

    assign i_text.ready      = !r_in_valid || consume;
    assign o_verdict.valid   = r_out_valid;
    assign o_verdict.verdict = r_verdict;

    assign step.fire      = consume;
    assign step.text_byte = r_in_byte;

    jtks_scan_core #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .o_verdict (core_verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_text.ready) begin
            r_in_valid <= i_text.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_text.valid && i_text.ready) begin
            r_in_byte <= i_text.text_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (consume && term) begin
            r_out_valid <= 1'b1;
        end else if (o_verdict.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && term) begin
            r_verdict <= core_verdict;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/jtks_scan_core.sv =====
// ----------------------------------------------------------------------------
// jtks_scan_core
// Per-byte scanner state: phase, depth, string/escape flags, key compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jtks_scan_core import jtks_pkg::*; #(
    parameter int MAX_DEPTH = 255
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_step      i_step,
    output logic [1:0]      o_verdict
);

    localparam int DW = $clog2(MAX_DEPTH + 1);

    t_phase         r_phase, n_phase;
    logic [DW-1:0]  r_depth, n_depth;
    logic           r_in_str, n_in_str;
    logic           r_skip, n_skip;
    logic           r_key_exp, n_key_exp;
    logic           r_key_cap, n_key_cap;
    logic [2:0]     r_key_pos, n_key_pos;
    logic           r_key_match, n_key_match;
    logic           r_saw_type, n_saw_type;
    logic           r_ovf, n_ovf;

    logic [7:0]     b;
    logic [DW-1:0]  dec_depth;

    assign b         = i_step.text_byte;
    assign dec_depth = (r_depth != '0) ? r_depth - DW'(1) : r_depth;

    // verdict for a terminator arriving now
    always_comb begin
        o_verdict = VERDICT_INVALID;
        if (r_phase == PH_NONOBJ) begin
            o_verdict = VERDICT_NONOBJ;
        end else if (r_phase == PH_DONE && !r_ovf) begin
            o_verdict = r_saw_type ? VERDICT_TYPE : VERDICT_NOTYPE;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_depth     = r_depth;
        n_in_str    = r_in_str;
        n_skip      = r_skip;
        n_key_exp   = r_key_exp;
        n_key_cap   = r_key_cap;
        n_key_pos   = r_key_pos;
        n_key_match = r_key_match;
        n_saw_type  = r_saw_type;
        n_ovf       = r_ovf;

        if (i_step.fire) begin
            if (b == CH_NUL) begin
                // terminator: back to the reset state
                n_phase     = PH_LEAD;
                n_depth     = '0;
                n_in_str    = 1'b0;
                n_skip      = 1'b0;
                n_key_exp   = 1'b1;
                n_key_cap   = 1'b0;
                n_key_pos   = '0;
                n_key_match = 1'b0;
                n_saw_type  = 1'b0;
                n_ovf       = 1'b0;
            end else begin
                case (r_phase)
                    PH_LEAD: begin
                        if (!(b inside {CH_SPACE, CH_TAB, CH_LF, CH_CR})) begin
                            if (b == CH_LBRACE) begin
                                n_phase   = PH_SCAN;
                                n_depth   = DW'(1);
                                n_key_exp = 1'b1;
                            end else begin
                                n_phase = PH_NONOBJ;
                            end
                        end
                    end
                    PH_SCAN: begin
                        if (r_in_str) begin
                            if (r_skip) begin
                                n_skip = 1'b0;
                            end else begin
                                if (r_key_cap) begin
                                    if (b == CH_QUOTE) begin
                                        if (r_key_match && r_key_pos == KEY_LEN)
                                            n_saw_type = 1'b1;
                                        n_key_cap = 1'b0;
                                    end else if (b == CH_BSLASH) begin
                                        n_key_match = 1'b0;
                                        n_key_cap   = 1'b0;
                                    end else if (r_key_pos < KEY_LEN &&
                                                 b == key_char(r_key_pos[1:0])) begin
                                        n_key_pos = r_key_pos + 3'd1;
                                    end else begin
                                        n_key_match = 1'b0;
                                    end
                                end
                                if (b == CH_BSLASH)
                                    n_skip = 1'b1;
                                else if (b == CH_QUOTE)
                                    n_in_str = 1'b0;
                            end
                        end else begin
                            if (b == CH_QUOTE) begin
                                if (r_depth == DW'(1) && r_key_exp) begin
                                    n_key_cap   = 1'b1;
                                    n_key_pos   = '0;
                                    n_key_match = 1'b1;
                                end
                                n_in_str = 1'b1;
                            end else if (b == CH_LBRACE || b == CH_LBRACK) begin
                                if (r_depth >= DW'(MAX_DEPTH))
                                    n_ovf = 1'b1;
                                else
                                    n_depth = r_depth + DW'(1);
                                n_key_exp = (b == CH_LBRACE);
                            end else if (b == CH_RBRACE || b == CH_RBRACK) begin
                                n_depth = dec_depth;
                                if (dec_depth == '0)
                                    n_phase = PH_DONE;
                            end else if (b == CH_COLON) begin
                                n_key_exp = 1'b0;
                            end else if (b == CH_COMMA) begin
                                n_key_exp = (r_depth == DW'(1));
                            end
                        end
                    end
                    default: ; // closed object or non-object: ignore until terminator
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LEAD;
            r_depth     <= '0;
            r_in_str    <= 1'b0;
            r_skip      <= 1'b0;
            r_key_exp   <= 1'b1;
            r_key_cap   <= 1'b0;
            r_key_pos   <= '0;
            r_key_match <= 1'b0;
            r_saw_type  <= 1'b0;
            r_ovf       <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_depth     <= n_depth;
            r_in_str    <= n_in_str;
            r_skip      <= n_skip;
            r_key_exp   <= n_key_exp;
            r_key_cap   <= n_key_cap;
            r_key_pos   <= n_key_pos;
            r_key_match <= n_key_match;
            r_saw_type  <= n_saw_type;
            r_ovf       <= n_ovf;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/jtks_checker.sv =====
// ----------------------------------------------------------------------------
// jtks_checker
// Port-level assertions for the type key scanner, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module jtks_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic [7:0] i_in_byte,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [1:0] i_out_verdict
);

    `JTKS_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "verdict dropped while stalled")
    `JTKS_ASSERT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> $stable(i_out_verdict), "verdict changed while stalled")
    `JTKS_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !i_out_valid, "verdict valid right after reset")
    // input only backs up behind a stalled verdict
    `JTKS_ASSERT(a_stall_cause, i_clk, i_rst_n, !i_in_ready |-> i_out_valid && !i_out_ready, "input stalled without output backpressure")
    // a terminator taken behind a stalled verdict waits exactly for that verdict
    `JTKS_ASSERT(a_term_wait, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_byte == 8'h00 && i_out_valid && !i_out_ready |=> i_in_ready == i_out_ready, "terminator not held behind pending verdict")

endmodule

bind json_top_level_type_key_scanner jtks_checker u_jtks_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_text.valid),
    .i_in_ready    (i_text.ready),
    .i_in_byte     (i_text.text_byte),
    .i_out_valid   (o_verdict.valid),
    .i_out_ready   (o_verdict.ready),
    .i_out_verdict (o_verdict.verdict)
);

`default_nettype wire

// ===== verif/json_top_level_type_key_scanner_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_top_level_type_key_scanner_tb
// Feeds JSON-like texts one byte per transaction, each closed by a zero byte,
// and checks every verdict against a cycle-free prediction of the scanner.
// Directed texts cover blank and empty input, non-objects, escapes, keys
// split by a backslash, repeated keys before a colon, mixed closers, depth
// overflow and truncation. Random texts are mostly well-formed objects with
// random content, plus broken, non-object and noise texts. Both sides stall at random.
// ----------------------------------------------------------------------------

import jtks_pkg::*;

class verdict_board;
    logic [1:0]  due_verdicts[$];
    int          errors;
    int unsigned depth_cap;
    t_phase      phase;
    int unsigned depth;
    bit          in_string;
    bit          skip_next;
    bit          key_expected;
    bit          capturing;
    bit          still_matches;
    bit          saw_type;
    bit          overflow;
    int          key_pos;
    logic [31:0] type_word = "type";

    function new(int unsigned cap);
        depth_cap = cap;
        errors    = 0;
        clear();
    endfunction

    function void clear();
        phase         = PH_LEAD;
        depth         = 0;
        in_string     = 1'b0;
        skip_next     = 1'b0;
        key_expected  = 1'b1;
        capturing     = 1'b0;
        key_pos       = 0;
        still_matches = 1'b0;
        saw_type      = 1'b0;
        overflow      = 1'b0;
    endfunction

    function void string_byte(logic [7:0] b);
        if (skip_next) begin
            skip_next = 1'b0;
            return;
        end
        if (capturing) begin
            if (b == CH_QUOTE) begin
                if (still_matches && key_pos == 4)
                    saw_type = 1'b1;
                capturing = 1'b0;
            end else if (b == CH_BSLASH) begin
                still_matches = 1'b0;
                capturing     = 1'b0;
            end else if (key_pos < 4 && b == type_word[31 - 8*key_pos -: 8]) begin
                key_pos++;
            end else begin
                still_matches = 1'b0;
            end
        end
        if (b == CH_BSLASH)
            skip_next = 1'b1;
        else if (b == CH_QUOTE)
            in_string = 1'b0;
    endfunction

    function void structure_byte(logic [7:0] b);
        if (b == CH_QUOTE) begin
            if (depth == 1 && key_expected) begin
                capturing     = 1'b1;
                key_pos       = 0;
                still_matches = 1'b1;
            end
            in_string = 1'b1;
        end else if (b == CH_LBRACE || b == CH_LBRACK) begin
            if (depth >= depth_cap)
                overflow = 1'b1;
            else
                depth++;
            key_expected = (b == CH_LBRACE);
        end else if (b == CH_RBRACE || b == CH_RBRACK) begin
            if (depth > 0)
                depth--;
            if (depth == 0)
                phase = PH_DONE;
        end else if (b == CH_COLON) begin
            key_expected = 1'b0;
        end else if (b == CH_COMMA) begin
            key_expected = (depth == 1);
        end
    endfunction

    // one accepted text byte; a terminator yields the expected verdict
    function void take_byte(logic [7:0] b);
        logic [1:0] verdict;
        if (b == CH_NUL) begin
            verdict = VERDICT_INVALID;
            if (phase == PH_NONOBJ)
                verdict = VERDICT_NONOBJ;
            else if (phase == PH_DONE && !overflow)
                verdict = saw_type ? VERDICT_TYPE : VERDICT_NOTYPE;
            due_verdicts.push_back(verdict);
            clear();
            return;
        end
        case (phase)
            PH_LEAD: begin
                if (b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR) begin
                end else if (b == CH_LBRACE) begin
                    phase        = PH_SCAN;
                    depth        = 1;
                    key_expected = 1'b1;
                end else begin
                    phase = PH_NONOBJ;
                end
            end
            PH_SCAN: begin
                if (in_string)
                    string_byte(b);
                else
                    structure_byte(b);
            end
            default: ;
        endcase
    endfunction

    function void match_verdict(logic [1:0] v);
        logic [1:0] want;
        if (due_verdicts.size() == 0) begin
            $error("verdict: no transaction expected, actual %0d", v);
            errors++;
            return;
        end
        want = due_verdicts.pop_front();
        if (v !== want) begin
            $error("verdict: expected %0d, actual %0d", want, v);
            errors++;
        end
    endfunction
endclass

module json_top_level_type_key_scanner_tb;

    localparam int unsigned DEPTH_CAP   = 255;
    localparam int          RAND_BYTES  = 2000;
    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam int          DRAIN       = 20;

    logic i_clk;
    logic i_rst_n;

    jtks_byte_if    text_if ();
    jtks_verdict_if verdict_if ();

    json_top_level_type_key_scanner #(
        .MAX_DEPTH (DEPTH_CAP)
    ) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_text    (text_if),
        .o_verdict (verdict_if)
    );

    verdict_board board;
    logic [7:0]   text_buf[$];
    int           sent_bytes;
    int           send_calm;
    int           take_calm;
    int           cycle_count;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("json_top_level_type_key_scanner_tb: errors");
            $finish;
        end
    end

    // transactions on both channels, sampled at the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (text_if.valid && text_if.ready)
                board.take_byte(text_if.text_byte);
            if (verdict_if.valid && verdict_if.ready)
                board.match_verdict(verdict_if.verdict);
        end
    end

    // mostly random waits, with runs of back-to-back transactions
    function automatic int pick_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            calm = $urandom_range(10, 60);
        return $urandom_range(0, 11);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_wait(send_calm);
        if (gap > 0) begin
            text_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        text_if.valid     <= 1'b1;
        text_if.text_byte <= b;
        do @(posedge i_clk); while (!text_if.ready);
        sent_bytes++;
    endtask

    task automatic send_text();
        text_buf.push_back(CH_NUL);
        foreach (text_buf[i])
            send_byte(text_buf[i]);
        text_buf.delete();
    endtask

    task automatic put_char(input logic [7:0] c);
        text_buf.push_back(c);
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++)
            put_char(s[i]);
    endtask

    task automatic maybe_blank();
        if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 3))
                0: put_char(CH_SPACE);
                1: put_char(CH_TAB);
                2: put_char(CH_LF);
                default: put_char(CH_CR);
            endcase
        end
    endtask

    // any nonzero byte that neither ends nor escapes a string
    task automatic put_plain_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
        put_char(c);
    endtask

    task automatic put_string();
        int n;
        n = $urandom_range(0, 8);
        put_char(CH_QUOTE);
        repeat (n) begin
            if ($urandom_range(0, 7) == 0) begin
                put_char(CH_BSLASH);
                put_char(8'($urandom_range(1, 255)));
            end else begin
                put_plain_char();
            end
        end
        put_char(CH_QUOTE);
    endtask

    task automatic put_key(input bit top);
        case ($urandom_range(0, top ? 11 : 15))
            0, 1, 2: put_str("\"type\"");
            3: put_str("\"typ\"");
            4: put_str("\"types\"");
            5: put_str("\"tyPe\"");
            6: put_str("\"ty\\pe\"");
            7: put_str("\"t\\\"ype\"");
            8: put_str("\"\"");
            default: put_string();
        endcase
    endtask

    task automatic put_scalar();
        int n;
        case ($urandom_range(0, 5))
            0, 1: put_string();
            2: begin
                n = $urandom_range(1, 4);
                repeat (n) put_char(8'($urandom_range(48, 57)));
            end
            3: put_str("true");
            4: put_str("null");
            default: put_str("\"type\"");
        endcase
    endtask

    // well-formed object with random members, nesting up to five levels
    task automatic put_object();
        bit is_obj[$];
        int members[$];
        int top;
        int pick;
        put_char(CH_LBRACE);
        is_obj.push_back(1'b1);
        members.push_back(0);
        while (is_obj.size() > 0) begin
            top = is_obj.size() - 1;
            maybe_blank();
            if (members[top] >= 5 || text_buf.size() > 150 || $urandom_range(0, 2) == 0) begin
                put_char(is_obj[top] ? CH_RBRACE : CH_RBRACK);
                void'(is_obj.pop_back());
                void'(members.pop_back());
            end else begin
                if (members[top] > 0)
                    put_char(CH_COMMA);
                members[top]++;
                if (is_obj[top]) begin
                    put_key(top == 0);
                    maybe_blank();
                    put_char(CH_COLON);
                    maybe_blank();
                end
                pick = $urandom_range(0, 9);
                if (pick < 2 && is_obj.size() < 5) begin
                    put_char(CH_LBRACE);
                    is_obj.push_back(1'b1);
                    members.push_back(0);
                end else if (pick < 4 && is_obj.size() < 5) begin
                    put_char(CH_LBRACK);
                    is_obj.push_back(1'b0);
                    members.push_back(0);
                end else begin
                    put_scalar();
                end
            end
        end
    endtask

    task automatic put_random_text();
        int kind;
        int n;
        kind = $urandom_range(0, 19);
        if (kind < 14) begin
            maybe_blank();
            put_object();
            if ($urandom_range(0, 3) == 0)
                put_scalar();
        end else if (kind < 16) begin
            put_object();
            if ($urandom_range(0, 1) == 0) begin
                n = $urandom_range(1, text_buf.size() - 1);
                repeat (n) void'(text_buf.pop_back());
            end else begin
                text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(1, 255));
            end
        end else if (kind < 18) begin
            maybe_blank();
            if ($urandom_range(0, 1) == 0) begin
                put_char(CH_LBRACK);
                put_scalar();
                put_char(CH_RBRACK);
            end else begin
                put_scalar();
            end
        end else begin
            n = $urandom_range(0, 20);
            repeat (n) put_char(8'($urandom_range(1, 255)));
        end
        send_text();
    endtask

    task automatic run_directed();
        send_text();
        put_str(" \t\n\r ");
        send_text();
        put_str("{}");
        send_text();
        put_str("{\"type\":1}");
        send_text();
        put_str("  \n{\"type\" : \"x\"}");
        send_text();
        put_str("x");
        send_text();
        put_str("[1,2]");
        send_text();
        put_str("}");
        send_text();
        put_str("{\"a\":1");
        send_text();
        put_str("{\"typ");
        send_text();
        // backslash right before the terminator
        put_str("{\"a\\");
        send_text();
        put_str("{\"ty\\pe\":1}");
        send_text();
        put_str("{\"t\\\"ype\":1}");
        send_text();
        put_str("{\"a\" \"type\":1}");
        send_text();
        put_str("{\"a\":[1}]");
        send_text();
        put_str("{\"a\":{\"type\":1}}");
        send_text();
        put_str("{\"a\":\"type\"}");
        send_text();
        put_str("{\"a\":1,\"type\":2}");
        send_text();
        put_str("{\"a\":[\"x\",\"type\"]}");
        send_text();
        put_str("{}xyz{\"type\":1}");
        send_text();
        put_str("{\"types\":1,\"typ\":2}");
        send_text();
        put_char(CH_LBRACE);
        put_char(CH_QUOTE);
        put_char(8'hFF);
        put_char(8'h80);
        put_str("\":1}");
        send_text();
        // deepest legal nesting
        put_char(CH_LBRACE);
        repeat (DEPTH_CAP - 1) put_char(CH_LBRACK);
        repeat (DEPTH_CAP - 1) put_char(CH_RBRACK);
        put_char(CH_RBRACE);
        send_text();
        // one opener too many
        repeat (DEPTH_CAP + 1) put_char(CH_LBRACE);
        repeat (DEPTH_CAP) put_char(CH_RBRACE);
        send_text();
    endtask

    initial begin
        board       = new(DEPTH_CAP);
        sent_bytes  = 0;
        send_calm   = 0;
        cycle_count = 0;
        i_rst_n           <= 1'b0;
        text_if.valid     <= 1'b0;
        text_if.text_byte <= 8'h00;
        verdict_if.ready  <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        while (sent_bytes < RAND_BYTES)
            put_random_text();
        text_if.valid <= 1'b0;

        while (board.due_verdicts.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (board.errors == 0)
            $display("json_top_level_type_key_scanner_tb: clean");
        else
            $display("json_top_level_type_key_scanner_tb: errors");
        $finish;
    end

    // verdict side: random stall before each transaction
    initial begin
        int stall;
        take_calm = 0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = pick_wait(take_calm);
            if (stall > 0) begin
                verdict_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            verdict_if.ready <= 1'b1;
            do @(posedge i_clk); while (!verdict_if.valid);
        end
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/jtks_pkg.sv
hdl/jtks_if.sv
hdl/jtks_scan_core.sv
hdl/json_top_level_type_key_scanner.sv
hdl/jtks_checker.sv
verif/json_top_level_type_key_scanner_tb.sv
